FILE: hw/rtl/cslpe_pkg.sv
package cslpe_pkg;

  localparam int unsigned CPU_COUNT   = 16;
  localparam int unsigned CPU_W       = 4;
  localparam int unsigned PAIR_COUNT  = CPU_COUNT / 2;
  localparam int unsigned SCROLL_STEPS = 6;
  localparam int unsigned FULL_PERIOD = 19;

  localparam logic [3:0] NIB_ON       = 4'h0;
  localparam logic [3:0] NIB_OFF      = 4'hF;
  localparam logic [3:0] NIB_QUIESCED = 4'h9;
  localparam logic [7:0] BOOT_RESET   = 8'h55;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  localparam logic [1:0] CFG_BOOTBUS = 2'd0;
  localparam logic [1:0] CFG_PRESENT = 2'd1;
  localparam logic [1:0] CFG_COUNT   = 2'd2;

  // Lane 1 is CPU A (high nibble), lane 0 is CPU B (low nibble).
  typedef struct packed {
    logic       boot_mode;
    logic       full;
    logic       blink;
    logic [7:0] boot_byte;
    logic [7:0] last_byte;
    logic [1:0] present;
    logic [7:0] dbg;
    logic [1:0] en;
    logic [1:0] idle;
    logic [1:0] seen;
    logic [2:0] scroll;
  } board_ctx_t;

  typedef struct packed {
    logic [7:0] led;
    logic [1:0] seen_set;
  } board_res_t;

  function automatic logic [3:0] scroll_nib(input logic [2:0] idx);
    logic [3:0] v;
    case (idx)
      3'd0:    v = 4'h7;
      3'd1:    v = 4'hB;
      3'd2:    v = 4'hD;
      3'd3:    v = 4'hE;
      3'd4:    v = 4'hD;
      3'd5:    v = 4'hB;
      default: v = 4'h7;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/cslpe_board_unit.sv
module cslpe_board_unit (
  input  cslpe_pkg::board_ctx_t ctx_i,
  output cslpe_pkg::board_res_t res_o
);

  logic [3:0] nib  [2];
  logic [1:0] seen_set;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      logic [3:0] d;
      logic [3:0] old;
      d   = ctx_i.dbg[i*4 +: 4];
      old = ctx_i.last_byte[i*4 +: 4];
      seen_set[i] = 1'b0;
      if (!ctx_i.present[i]) begin
        nib[i] = cslpe_pkg::NIB_ON;
      end else if (d != 4'h0) begin
        nib[i] = ctx_i.blink ? ~d : cslpe_pkg::NIB_OFF;
      end else if (!ctx_i.en[i]) begin
        nib[i] = cslpe_pkg::NIB_QUIESCED;
      end else begin
        nib[i] = (ctx_i.full || ctx_i.seen[i]) ? cslpe_pkg::scroll_nib(ctx_i.scroll) : old;
        seen_set[i] = ctx_i.full && ctx_i.idle[i];
      end
    end
  end

  // Boot pattern replaces both nibbles and never touches the idle history.
  always_comb begin
    if (ctx_i.boot_mode) begin
      res_o.led      = ~ctx_i.boot_byte;
      res_o.seen_set = 2'b00;
    end else begin
      res_o.led      = {nib[1], nib[0]};
      res_o.seen_set = seen_set;
    end
  end

endmodule

FILE: hw/rtl/cpu_status_led_pattern_engine.sv
// LED pattern engine for boards carrying two CPUs each. A periodic tick walks
// the sixteen CPU slots in ascending order, one per cycle unless the output
// stalls, and writes one LED byte for every boot-bus board, stopping after the
// configured board count (zero visits all). A tick keeps the input stalled from
// acceptance through any output stall until the cycle that delivers its final
// board write, or until the full walk ends when no board is written, so no new
// request is taken while a tick is in progress. A set command keeps the input
// stalled while its write waits for the output and writes at most one byte, so
// no new request is taken until it ends. All LED bytes come from one shared
// board unit driven by the walk counter; configuration writes are always ready
// and must only be issued idle.
module cpu_status_led_pattern_engine (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [3:0]  target_cpu_i,
  input  logic [3:0]  debug_nibble_i,
  input  logic [15:0] enabled_mask_i,
  input  logic [15:0] idle_mask_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  board_id_o,
  output logic [7:0]  led_byte_o,
  output logic        last_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_ONE  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [15:0] bootbus_q, present_q;
  logic [4:0]  bus_count_q;

  logic [2:0]  scroll_q;
  logic [4:0]  full_cnt_q;
  logic        blink_q;
  logic [15:0] seen_q;
  logic [7:0]  boot_q;
  logic [7:0]  dbg_q  [cslpe_pkg::PAIR_COUNT];
  logic [7:0]  lastw_q [cslpe_pkg::CPU_COUNT];

  logic [3:0]  brd_q;
  logic [4:0]  found_q;
  logic [15:0] en_q, idle_q;

  logic        out_valid_q;
  logic [3:0]  out_board_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;

  logic        in_acc;
  logic        out_free;
  logic        busy;
  logic        brd_owns;
  logic        emit;
  logic        scan_last;
  logic        emit_last;
  logic        tick_done;
  logic [3:0]  cpu_a, cpu_b;
  logic [2:0]  pair;
  logic        full;
  logic [3:0]  set_board;

  cslpe_pkg::board_ctx_t ctx;
  cslpe_pkg::board_res_t res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;

  assign busy      = (state_q == ST_SCAN) || (state_q == ST_ONE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign brd_owns  = bootbus_q[brd_q];
  assign emit      = busy && brd_owns && out_free;
  assign pair      = brd_q[3:1];
  assign cpu_a     = {brd_q[3:1], 1'b0};
  assign cpu_b     = {brd_q[3:1], 1'b1};
  assign full      = (full_cnt_q == 5'd0);
  assign set_board = bootbus_q[target_cpu_i] ? target_cpu_i : (target_cpu_i ^ 4'd1);

  // Final write when the count is reached or no boot-bus board lies above.
  assign scan_last = ((found_q + 5'd1) == bus_count_q) ||
                     ((bootbus_q >> ({1'b0, brd_q} + 5'd1)) == 16'd0);
  assign emit_last = (state_q == ST_ONE) ? 1'b1 : scan_last;
  assign tick_done = (state_q == ST_SCAN) &&
                     ((emit && scan_last) || (!brd_owns && brd_q == 4'd15));

  always_comb begin
    ctx.boot_mode = (present_q == 16'd0) && (dbg_q[pair] == 8'd0);
    ctx.full      = full;
    ctx.blink     = blink_q;
    ctx.boot_byte = boot_q;
    ctx.last_byte = lastw_q[brd_q];
    ctx.present   = {present_q[cpu_a], present_q[cpu_b]};
    ctx.dbg       = dbg_q[pair];
    ctx.en        = {en_q[cpu_a], en_q[cpu_b]};
    ctx.idle      = {idle_q[cpu_a], idle_q[cpu_b]};
    ctx.seen      = {seen_q[cpu_a], seen_q[cpu_b]};
    ctx.scroll    = scroll_q;
  end

  cslpe_board_unit u_board (
    .ctx_i (ctx),
    .res_o (res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (cmd_i == cslpe_pkg::CMD_SET) ? ST_ONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tick_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_ONE: begin
        if (!brd_owns || emit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bootbus_q   <= '0;
      present_q   <= '0;
      bus_count_q <= '0;
      scroll_q    <= '0;
      full_cnt_q  <= '0;
      blink_q     <= 1'b1;
      seen_q      <= '0;
      boot_q      <= cslpe_pkg::BOOT_RESET;
      brd_q       <= '0;
      found_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < int'(cslpe_pkg::PAIR_COUNT); i++) begin
        dbg_q[i] <= '0;
      end
      for (int i = 0; i < int'(cslpe_pkg::CPU_COUNT); i++) begin
        lastw_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          cslpe_pkg::CFG_BOOTBUS: bootbus_q   <= cfg_data_i;
          cslpe_pkg::CFG_PRESENT: present_q   <= cfg_data_i;
          cslpe_pkg::CFG_COUNT:   bus_count_q <= cfg_data_i[4:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        found_q <= '0;
        if (cmd_i == cslpe_pkg::CMD_SET) begin
          if (target_cpu_i[0]) begin
            dbg_q[target_cpu_i[3:1]][3:0] <= debug_nibble_i;
          end else begin
            dbg_q[target_cpu_i[3:1]][7:4] <= debug_nibble_i;
          end
          blink_q <= 1'b1;
          brd_q   <= set_board;
        end else begin
          if (full) begin
            seen_q <= '0;
          end
          blink_q <= ~blink_q;
          brd_q   <= '0;
        end
      end

      if (emit) begin
        lastw_q[brd_q] <= res.led;
        found_q        <= found_q + 5'd1;
        if (ctx.boot_mode) begin
          boot_q <= res.led;
        end
        seen_q[cpu_a] <= seen_q[cpu_a] | res.seen_set[1];
        seen_q[cpu_b] <= seen_q[cpu_b] | res.seen_set[0];
      end

      // Advance the walk past boards without boot bus, or after a write.
      if (state_q == ST_SCAN && !tick_done && (emit || !brd_owns)) begin
        brd_q <= brd_q + 4'd1;
      end

      if (tick_done) begin
        scroll_q   <= (scroll_q == 3'(cslpe_pkg::SCROLL_STEPS - 1)) ? 3'd0 : scroll_q + 3'd1;
        full_cnt_q <= (full_cnt_q == 5'(cslpe_pkg::FULL_PERIOD - 1)) ? 5'd0
                                                                      : full_cnt_q + 5'd1;
      end

      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      en_q   <= enabled_mask_i;
      idle_q <= idle_mask_i;
    end
    if (emit) begin
      out_board_q <= brd_q;
      out_byte_q  <= res.led;
      out_last_q  <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign board_id_o  = out_board_q;
  assign led_byte_o  = out_byte_q;
  assign last_o      = out_last_q;

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
  import cslpe_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 24;
  localparam int PHASE_ITEMS  = 20;
  // Scroll sequence, first step in the top nibble.
  localparam logic [23:0] SCROLL_SEQ = 24'h7BDEDB;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  target;
    logic [3:0]  nibble;
    logic [15:0] en;
    logic [15:0] idle;
  } led_req_t;

  typedef struct packed {
    logic [3:0] board;
    logic [7:0] led;
    logic       last;
  } led_write_t;

  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [1:0] reg_idx;
    logic [15:0] reg_data;
    led_req_t   req;
    logic       typed;
    led_write_t exp_write;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        cmd_i;
  logic [3:0]  target_cpu_i;
  logic [3:0]  debug_nibble_i;
  logic [15:0] enabled_mask_i;
  logic [15:0] idle_mask_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  board_id_o;
  logic [7:0]  led_byte_o;
  logic        last_o;

  cpu_status_led_pattern_engine dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .target_cpu_i   (target_cpu_i),
    .debug_nibble_i (debug_nibble_i),
    .enabled_mask_i (enabled_mask_i),
    .idle_mask_i    (idle_mask_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .board_id_o     (board_id_o),
    .led_byte_o     (led_byte_o),
    .last_o         (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // LED engine shadow state
  logic [15:0] bootbus_cfg;
  logic [15:0] present_cfg;
  logic [4:0]  count_cfg;
  logic [2:0]  scroll_pos;
  logic [4:0]  full_cnt;
  logic        blink;
  logic [15:0] idle_hist;
  logic [3:0]  dbg_nib [CPU_COUNT];
  logic [7:0]  shown [CPU_COUNT];
  logic [7:0]  boot_pat;

  led_write_t step_writes[$];
  led_write_t led_expect[$];
  dir_row_t   directed[$];

  int mismatches    = 0;
  int quiet_cycles  = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_kicks    = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  logic       typed_now;
  led_write_t typed_write;

  function automatic logic [3:0] lane_nibble(int cpu, int board, bit hi, bit full,
                                             logic [15:0] en, logic [15:0] idle);
    logic [3:0] v;
    if (!present_cfg[cpu]) return NIB_ON;
    if (dbg_nib[cpu] != 4'h0) return blink ? ~dbg_nib[cpu] : NIB_OFF;
    if (!en[cpu]) return NIB_QUIESCED;
    if (full || idle_hist[cpu]) v = SCROLL_SEQ[23 - 4 * scroll_pos -: 4];
    else v = hi ? shown[board][7:4] : shown[board][3:0];
    if (full && idle[cpu]) idle_hist[cpu] = 1'b1;
    return v;
  endfunction

  task automatic refresh_board(input int board, input logic [15:0] en,
                               input logic [15:0] idle);
    int a;
    int b;
    bit full;
    led_write_t w;
    full = (full_cnt == 5'd0);
    if (!bootbus_cfg[board]) return;
    a = board & ~1;
    b = a + 1;
    if (present_cfg == 16'h0 && dbg_nib[a] == 4'h0 && dbg_nib[b] == 4'h0) begin
      boot_pat = ~boot_pat;
      w.led = boot_pat;
    end else begin
      w.led[7:4] = lane_nibble(a, board, 1'b1, full, en, idle);
      w.led[3:0] = lane_nibble(b, board, 1'b0, full, en, idle);
    end
    shown[board] = w.led;
    w.board = 4'(board);
    w.last = 1'b0;
    step_writes.push_back(w);
  endtask

  task automatic predict_request(input led_req_t r);
    int found;
    step_writes.delete();
    if (r.cmd == CMD_SET) begin
      dbg_nib[r.target] = r.nibble;
      blink = 1'b1;
      refresh_board(bootbus_cfg[r.target] ? int'(r.target) : int'(r.target ^ 4'd1),
                    r.en, r.idle);
    end else begin
      if (full_cnt == 5'd0) idle_hist = '0;
      blink = ~blink;
      found = 0;
      for (int bd = 0; bd < CPU_COUNT; bd++) begin
        if (bootbus_cfg[bd]) begin
          refresh_board(bd, r.en, r.idle);
          found++;
          if (found == int'(count_cfg)) break;
        end
      end
      scroll_pos = (scroll_pos == 3'(SCROLL_STEPS - 1)) ? 3'd0 : scroll_pos + 3'd1;
      full_cnt = (full_cnt == 5'(FULL_PERIOD - 1)) ? 5'd0 : full_cnt + 5'd1;
    end
    if (step_writes.size() > 0) step_writes[step_writes.size() - 1].last = 1'b1;
  endtask

  task automatic reset_shadow();
    bootbus_cfg = '0;
    present_cfg = '0;
    count_cfg   = '0;
    scroll_pos  = '0;
    full_cnt    = '0;
    blink       = 1'b1;
    idle_hist   = '0;
    boot_pat    = BOOT_RESET;
    for (int i = 0; i < CPU_COUNT; i++) begin
      dbg_nib[i] = '0;
      shown[i] = '0;
    end
  endtask

  // Check LED writes, predict accepted requests, mirror register writes.
  always @(posedge clk_i) begin : monitor
    led_req_t   req_now;
    led_write_t got;
    led_write_t want;
    bit         moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        got.board = board_id_o;
        got.led = led_byte_o;
        got.last = last_o;
        if (led_expect.size() == 0) begin
          $display("%0t: unexpected LED write: expected none, got board %0h led %0h last %0b",
                   $time, got.board, got.led, got.last);
          mismatches++;
        end else begin
          want = led_expect.pop_front();
          if (got.board !== want.board) begin
            $display("%0t: board_id expected %0h got %0h", $time, want.board, got.board);
            mismatches++;
          end
          if (got.led !== want.led) begin
            $display("%0t: led_byte expected %0h got %0h", $time, want.led, got.led);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        req_now.cmd = cmd_i;
        req_now.target = target_cpu_i;
        req_now.nibble = debug_nibble_i;
        req_now.en = enabled_mask_i;
        req_now.idle = idle_mask_i;
        predict_request(req_now);
        if (typed_now) begin
          step_writes.delete();
          step_writes.push_back(typed_write);
        end
        foreach (step_writes[k]) led_expect.push_back(step_writes[k]);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        case (cfg_index_i)
          CFG_BOOTBUS: bootbus_cfg = cfg_data_i;
          CFG_PRESENT: present_cfg = cfg_data_i;
          CFG_COUNT:   count_cfg = cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (moved) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("cpu_status_led_pattern_engine verification failed");
          $finish;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when kicked.
  always @(negedge clk_i) begin
    if (hold_kicks != hold_served) begin
      hold_served = hold_kicks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  function automatic dir_row_t cfg_row(logic [1:0] idx, logic [15:0] data);
    dir_row_t d;
    d = '0;
    d.kind = ROW_CFG;
    d.reg_idx = idx;
    d.reg_data = data;
    return d;
  endfunction

  function automatic dir_row_t req_row(logic cmd, logic [3:0] tgt, logic [3:0] nib,
                                       logic [15:0] en, logic [15:0] idle,
                                       logic typed, logic [3:0] bd, logic [7:0] led);
    dir_row_t d;
    d = '0;
    d.kind = ROW_REQ;
    d.req = '{cmd, tgt, nib, en, idle};
    d.typed = typed;
    d.exp_write = '{bd, led, 1'b1};
    return d;
  endfunction

  function automatic logic [15:0] random_mask();
    case ($urandom_range(0, 3))
      0:       return 16'hFFFF;
      1:       return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic led_req_t random_req();
    led_req_t r;
    r.cmd = ($urandom_range(0, 99) < 30) ? CMD_SET : CMD_TICK;
    r.target = 4'($urandom_range(0, 15));
    r.nibble = ($urandom_range(0, 3) == 0) ? 4'h0 : 4'($urandom_range(0, 15));
    r.en = random_mask();
    r.idle = random_mask();
    return r;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_index_i = idx;
    cfg_data_i = data;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Leaves the request line high at the falling edge after acceptance.
  task automatic send_req(input led_req_t r, input logic typed, input led_write_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    cmd_i = r.cmd;
    target_cpu_i = r.target;
    debug_nibble_i = r.nibble;
    enabled_mask_i = r.en;
    idle_mask_i = r.idle;
    typed_now = typed;
    typed_write = w;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop the request line, drain all writes, then let a walk with no write finish.
  task automatic settle();
    in_valid_i = 1'b0;
    while (led_expect.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    led_req_t r;
    reset_shadow();
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    cmd_i = CMD_TICK;
    target_cpu_i = '0;
    debug_nibble_i = '0;
    enabled_mask_i = '0;
    idle_mask_i = '0;
    out_stall_i = 1'b0;
    typed_now = 1'b0;
    typed_write = '0;

    // no boot-bus board after reset: a tick writes nothing
    directed.push_back(req_row(CMD_TICK, 4'd0, 4'd0, 16'h0000, 16'h0000, 1'b0, 4'd0, 8'h00));
    directed.push_back(cfg_row(CFG_BOOTBUS, 16'hFFFF));
    directed.push_back(cfg_row(CFG_PRESENT, 16'h0000));
    directed.push_back(cfg_row(CFG_COUNT, 16'd1));
    // boot pattern toggles on the first board
    directed.push_back(req_row(CMD_TICK, 4'd0, 4'd0, 16'h0000, 16'h0000, 1'b1, 4'd0, 8'hAA));
    directed.push_back(req_row(CMD_TICK, 4'd0, 4'd0, 16'hFFFF, 16'hFFFF, 1'b1, 4'd0, 8'h55));
    // debug nibble with no CPU present lights all
    directed.push_back(req_row(CMD_SET, 4'd1, 4'hF, 16'hFFFF, 16'h0000, 1'b1, 4'd1, 8'h00));
    directed.push_back(req_row(CMD_SET, 4'd1, 4'h0, 16'hFFFF, 16'h0000, 1'b1, 4'd1, 8'hAA));
    directed.push_back(cfg_row(CFG_PRESENT, 16'hFFFF));
    directed.push_back(cfg_row(CFG_COUNT, 16'd0));
    directed.push_back(req_row(CMD_TICK, 4'd0, 4'd0, 16'hFFFF, 16'h0000, 1'b0, 4'd0, 8'h00));
    directed.push_back(req_row(CMD_TICK, 4'd0, 4'd0, 16'hFFFF, 16'hFFFF, 1'b0, 4'd0, 8'h00));
    // both CPUs disabled: quiesced
    directed.push_back(req_row(CMD_SET, 4'd4, 4'h0, 16'h0000, 16'h0000, 1'b1, 4'd4, 8'h99));
    directed.push_back(req_row(CMD_SET, 4'd2, 4'h5, 16'hFFFF, 16'h0000, 1'b0, 4'd0, 8'h00));
    directed.push_back(req_row(CMD_TICK, 4'd0, 4'd0, 16'hFFFF, 16'h0000, 1'b0, 4'd0, 8'h00));
    directed.push_back(req_row(CMD_SET, 4'd15, 4'hF, 16'hFFFF, 16'hFFFF, 1'b0, 4'd0, 8'h00));
    directed.push_back(req_row(CMD_SET, 4'd2, 4'h0, 16'hFFFF, 16'h0000, 1'b0, 4'd0, 8'h00));
    directed.push_back(req_row(CMD_SET, 4'd15, 4'h0, 16'h0000, 16'hFFFF, 1'b0, 4'd0, 8'h00));
    directed.push_back(cfg_row(CFG_PRESENT, 16'h5555));
    directed.push_back(req_row(CMD_SET, 4'd7, 4'h0, 16'hFFFF, 16'h0000, 1'b0, 4'd0, 8'h00));
    directed.push_back(cfg_row(CFG_BOOTBUS, 16'h5555));
    directed.push_back(cfg_row(CFG_COUNT, 16'd16));
    directed.push_back(req_row(CMD_TICK, 4'd0, 4'd0, 16'hAAAA, 16'h5555, 1'b0, 4'd0, 8'h00));
    // odd target without boot bus: partner's board
    directed.push_back(req_row(CMD_SET, 4'd3, 4'hA, 16'hFFFF, 16'h0000, 1'b0, 4'd0, 8'h00));
    // neither CPU of the pair owns a boot bus: no write
    directed.push_back(cfg_row(CFG_BOOTBUS, 16'h0001));
    directed.push_back(req_row(CMD_SET, 4'd5, 4'h3, 16'hFFFF, 16'h0000, 1'b0, 4'd0, 8'h00));
    directed.push_back(req_row(CMD_SET, 4'd5, 4'h0, 16'hFFFF, 16'h0000, 1'b0, 4'd0, 8'h00));
    // count beyond the board count
    directed.push_back(cfg_row(CFG_BOOTBUS, 16'h0003));
    directed.push_back(cfg_row(CFG_COUNT, 16'd5));
    directed.push_back(req_row(CMD_TICK, 4'd0, 4'd0, 16'hFFFF, 16'hFFFF, 1'b0, 4'd0, 8'h00));
    directed.push_back(cfg_row(CFG_BOOTBUS, 16'hFFFF));
    directed.push_back(cfg_row(CFG_PRESENT, 16'h0000));
    directed.push_back(cfg_row(CFG_COUNT, 16'd16));
    directed.push_back(req_row(CMD_TICK, 4'd0, 4'd0, 16'h0000, 16'h0000, 1'b0, 4'd0, 8'h00));

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 37;
    recv_idle_pct = 85;
    foreach (directed[k]) begin
      if (directed[k].kind == ROW_CFG) begin
        settle();
        write_reg(directed[k].reg_idx, directed[k].reg_data);
      end else begin
        send_req(directed[k].req, directed[k].typed, directed[k].exp_write);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(CFG_BOOTBUS, 16'hFFFF);
          write_reg(CFG_PRESENT, 16'hFFFF);
          write_reg(CFG_COUNT, 16'd0);
        end
        1: begin
          send_idle_pct = 85;
          recv_idle_pct = 37;
          write_reg(CFG_BOOTBUS, 16'($urandom()) | (16'h1 << $urandom_range(0, 15)));
          write_reg(CFG_PRESENT, 16'($urandom()));
          write_reg(CFG_COUNT, 16'($urandom_range(0, 16)));
        end
        2: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_reg(CFG_BOOTBUS, 16'($urandom()) | 16'h0001);
          write_reg(CFG_PRESENT, 16'h0000);
          write_reg(CFG_COUNT, 16'd16);
        end
        default: begin
          write_reg(CFG_BOOTBUS, 16'($urandom()) | (16'h1 << $urandom_range(0, 15)));
          write_reg(CFG_PRESENT, random_mask());
          write_reg(CFG_COUNT, 16'($urandom_range(0, 16)));
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // back up the output while requests keep coming
        if (ph == 0 && i == 4) hold_kicks++;
        if (i == 15) begin
          while (led_expect.size() != 0) begin
            in_valid_i = 1'b0;
            @(negedge clk_i);
          end
        end
        r = random_req();
        send_req(r, 1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("cpu_status_led_pattern_engine verification clean");
    end else begin
      $display("cpu_status_led_pattern_engine verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/cslpe_pkg.sv
hw/rtl/cslpe_board_unit.sv
hw/rtl/cpu_status_led_pattern_engine.sv
tb/sv/tb_top.sv
